// ----- rtl/soft_uart_8n1_with_rx_ring_top_assert.svh -----
// assertion macros shared by the uart rtl
`ifndef SOFT_UART_8N1_WITH_RX_RING_TOP_ASSERT_SVH
`define SOFT_UART_8N1_WITH_RX_RING_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SUART_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SUART_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/suart_pkg.sv -----
package suart_pkg;

    // receive ring size
    localparam int RING_DEPTH = 256;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    // frame bit counts
    localparam logic [3:0] RX_DONE_COUNT = 4'd9;
    localparam logic [3:0] TX_DATA_LAST  = 4'd9;
    localparam logic [3:0] TX_DONE_COUNT = 4'd13;

    // configuration register indexes
    localparam logic CFG_BIT_PERIOD  = 1'b0;
    localparam logic CFG_PORT_ENABLE = 1'b1;

    // configuration seen by the rx and tx engines
    typedef struct packed {
        logic [15:0] bit_period;
        logic        port_enable;
    } cfg_t;

    // byte handed from the receiver to the ring
    typedef struct packed {
        logic       push;
        logic [7:0] data;
    } rx_push_t;

endpackage

// ----- rtl/soft_uart_8n1_with_rx_ring_top.sv -----
// Timer-driven 8N1 UART with a receive ring. Every input request is one timer
// tick with the sampled rx pin and optional transmit and ring-read requests;
// every accepted request yields exactly one result with the transmit line,
// transmitter busy flag, popped byte and ring-empty flag as they stand after
// that tick. One request is taken per clock when not stalled: the rx, tx and
// ring state registers double as the result register, so a new request is
// accepted in the same cycle the previous result is taken. The ring is a
// 256-byte memory with one write port for received bytes and one registered
// read port for pops; a pop sees the ring as it was before the tick. The ring
// has no full check and silently overwrites unread data. Configuration writes
// (bit_period at index 0, port_enable at index 1) belong to idle periods.
`include "soft_uart_8n1_with_rx_ring_top_assert.svh"

module soft_uart_8n1_with_rx_ring_top
    import suart_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_pin, tx_start, tx_byte[7:0], rd_req, zero pad
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // tx_pin, tx_busy, rd_valid, rd_data[7:0], rx_empty, pad
);

    cfg_t       cfg_reg;
    logic       m_valid_reg;
    logic       tick;
    rx_push_t   push;
    logic       tx_pin, tx_busy, rd_valid, rx_empty;
    logic [7:0] rd_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_period  <= 16'd1;
            cfg_reg.port_enable <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_BIT_PERIOD:  cfg_reg.bit_period  <= cfg_wdata;
                CFG_PORT_ENABLE: cfg_reg.port_enable <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // a tick runs when the previous result is gone or leaves this cycle
    assign s_tready = !m_valid_reg || m_tready;
    assign tick     = s_tvalid && s_tready;

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            m_valid_reg <= s_tvalid;
        end
    end

    suart_rx u_rx (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick),
        .cfg    (cfg_reg),
        .rx_pin (s_tdata[0]),
        .push   (push)
    );

    suart_tx u_tx (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick),
        .cfg      (cfg_reg),
        .tx_start (s_tdata[1]),
        .tx_byte  (s_tdata[9:2]),
        .tx_pin   (tx_pin),
        .tx_busy  (tx_busy)
    );

    suart_ring u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick),
        .push     (push),
        .rd_req   (s_tdata[10]),
        .rd_valid (rd_valid),
        .rd_data  (rd_data),
        .rx_empty (rx_empty)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, rx_empty, rd_data, rd_valid, tx_busy, tx_pin};

    `SUART_ASSERT_NEXT(a_top_tick_gives_result, tick, m_tvalid,
        "accepted tick produced no result")
    `SUART_ASSERT_NOW(a_top_no_tick_on_stall, m_valid_reg && !m_tready, !tick,
        "tick taken while result stalled")
    `SUART_ASSERT_NOW(a_top_data_needs_valid, !rd_valid, rd_data == 8'd0,
        "popped byte nonzero without a pop")

endmodule

// ----- rtl/suart_rx.sv -----
`include "soft_uart_8n1_with_rx_ring_top_assert.svh"

module suart_rx
    import suart_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     tick,
    input  cfg_t     cfg,
    input  logic     rx_pin,
    output rx_push_t push
);

    logic        active_reg, active_next;
    logic        prev_reg, prev_next;
    logic [16:0] timer_reg, timer_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [7:0]  shift_reg, shift_next;
    logic [16:0] target;
    logic [3:0]  cnt_inc;

    // first sample waits an extra sixteenth of a bit
    assign target  = (cnt_reg == 4'd0)
                   ? ({1'b0, cfg.bit_period} + {5'd0, cfg.bit_period[15:4]})
                   : {1'b0, cfg.bit_period};
    assign cnt_inc = cnt_reg + 4'd1;

    // receive sequencing for one tick
    always_comb
    begin
        active_next = active_reg;
        timer_next  = timer_reg;
        cnt_next    = cnt_reg;
        shift_next  = shift_reg;
        prev_next   = rx_pin;
        push.push   = 1'b0;
        push.data   = shift_reg;
        if (!cfg.port_enable)
        begin
            active_next = 1'b0;
            cnt_next    = 4'd0;
            timer_next  = 17'd0;
        end
        else if (!active_reg)
        begin
            if (prev_reg && !rx_pin)
            begin
                active_next = 1'b1;
                timer_next  = 17'd0;
                cnt_next    = 4'd0;
                shift_next  = 8'd0;
            end
        end
        else if (timer_reg != target)
        begin
            timer_next = timer_reg + 17'd1;
        end
        else
        begin
            timer_next = 17'd0;
            if (cnt_inc < RX_DONE_COUNT)
            begin
                cnt_next = cnt_inc;
                shift_next[cnt_reg[2:0]] = rx_pin;
            end
            else
            begin
                // stop bit sample ignored, byte goes to the ring
                push.push   = 1'b1;
                active_next = 1'b0;
                cnt_next    = 4'd0;
            end
        end
        if (!tick)
        begin
            push.push = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            prev_reg   <= 1'b1;
            timer_reg  <= 17'd0;
            cnt_reg    <= 4'd0;
            shift_reg  <= 8'd0;
        end
        else if (tick)
        begin
            active_reg <= active_next;
            prev_reg   <= prev_next;
            timer_reg  <= timer_next;
            cnt_reg    <= cnt_next;
            shift_reg  <= shift_next;
        end
    end

    `SUART_ASSERT_NOW(a_rx_push_active, push.push, active_reg && cnt_reg == 4'd8,
        "rx pushed a byte outside the stop bit sample")
    `SUART_ASSERT_NEXT(a_rx_disable_idle, tick && !cfg.port_enable,
        !active_reg && cnt_reg == 4'd0, "rx not idle after disabled tick")
    `SUART_ASSERT_NOW(a_rx_count_range, active_reg, cnt_reg <= 4'd8,
        "rx bit count out of range")

endmodule

// ----- rtl/suart_tx.sv -----
`include "soft_uart_8n1_with_rx_ring_top_assert.svh"

module suart_tx
    import suart_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick,
    input  cfg_t       cfg,
    input  logic       tx_start,
    input  logic [7:0] tx_byte,
    output logic       tx_pin,
    output logic       tx_busy
);

    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] timer_reg, timer_next;
    logic [7:0]  shift_reg, shift_next;
    logic        line_reg, line_next;
    logic [3:0]  cnt_inc;
    logic [2:0]  bit_sel;

    assign cnt_inc = cnt_reg + 4'd1;
    assign bit_sel = 3'(cnt_reg - 4'd1);

    // transmit sequencing for one tick
    always_comb
    begin
        cnt_next   = cnt_reg;
        timer_next = timer_reg;
        shift_next = shift_reg;
        line_next  = line_reg;
        if (!cfg.port_enable)
        begin
            cnt_next   = 4'd0;
            timer_next = 16'd0;
            line_next  = 1'b1;
        end
        else if (cnt_reg == 4'd0)
        begin
            if (tx_start)
            begin
                shift_next = tx_byte;
                line_next  = 1'b0;
                cnt_next   = 4'd1;
                timer_next = 16'd0;
            end
        end
        else if (timer_reg != cfg.bit_period)
        begin
            timer_next = timer_reg + 16'd1;
        end
        else
        begin
            timer_next = 16'd0;
            if (cnt_inc > TX_DATA_LAST)
            begin
                // stop level, held until the guard time runs out
                line_next = 1'b1;
                cnt_next  = (cnt_inc >= TX_DONE_COUNT) ? 4'd0 : cnt_inc;
            end
            else
            begin
                line_next = shift_reg[bit_sel];
                cnt_next  = cnt_inc;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= 4'd0;
            timer_reg <= 16'd0;
            shift_reg <= 8'd0;
            line_reg  <= 1'b1;
        end
        else if (tick)
        begin
            cnt_reg   <= cnt_next;
            timer_reg <= timer_next;
            shift_reg <= shift_next;
            line_reg  <= line_next;
        end
    end

    assign tx_pin  = line_reg;
    assign tx_busy = (cnt_reg != 4'd0);

    `SUART_ASSERT_NOW(a_tx_idle_high, cnt_reg == 4'd0, line_reg,
        "tx line low while idle")
    `SUART_ASSERT_NOW(a_tx_start_low, cnt_reg == 4'd1, !line_reg,
        "tx start bit not low")
    `SUART_ASSERT_NEXT(a_tx_disable_idle, tick && !cfg.port_enable,
        cnt_reg == 4'd0 && timer_reg == 16'd0, "tx not idle after disabled tick")

endmodule

// ----- rtl/suart_ring.sv -----
`include "soft_uart_8n1_with_rx_ring_top_assert.svh"

module suart_ring
    import suart_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick,
    input  rx_push_t   push,
    input  logic       rd_req,
    output logic       rd_valid,
    output logic [7:0] rd_data,
    output logic       rx_empty
);

    logic [7:0]         mem [RING_DEPTH];
    logic [7:0]         mem_q;
    logic [RING_AW-1:0] head_reg, head_next;
    logic [RING_AW-1:0] tail_reg, tail_next;
    logic               rd_valid_reg;
    logic               pop;
    logic               empty;

    assign empty = (head_reg == tail_reg);
    assign pop   = tick && rd_req && !empty;

    // pointer advance with wrap at the ring size
    assign head_next = (head_reg == RING_AW'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_next = (tail_reg == RING_AW'(RING_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    // ring storage, one write and one registered read per tick
    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            mem[tail_reg] <= push.data;
        end
        if (pop)
        begin
            mem_q <= mem[head_reg];
        end
    end

    // pointers and read status; no full check, overrun drops unread bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else if (tick)
        begin
            rd_valid_reg <= pop;
            if (pop)
            begin
                head_reg <= head_next;
            end
            if (push.push)
            begin
                tail_reg <= tail_next;
            end
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_data  = rd_valid_reg ? mem_q : 8'd0;
    assign rx_empty = empty;

    `SUART_ASSERT_NEXT(a_ring_pop_moves_head, pop, head_reg != $past(head_reg),
        "ring head did not advance on pop")
    `SUART_ASSERT_NEXT(a_ring_hold_head, !pop, head_reg == $past(head_reg),
        "ring head moved without a pop")
    `SUART_ASSERT_NEXT(a_ring_push_moves_tail, push.push, tail_reg != $past(tail_reg),
        "ring tail did not advance on push")

endmodule
